// File: rtl/core/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared types, constants and a helper function for the detail coring and
// enhancement block.
// ----------------------------------------------------------------------------
package dce_pkg;

    // Default line store depth (maximum line width in pixels).
    localparam int MAX_WIDTH = 2048;

    // Field widths.
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int TH_W   = 8;
    localparam int GAIN_W = 12;
    localparam int ROW_W  = 12;
    localparam int IDX_W  = 2;
    localparam int MAG_W  = PIX_W + 1;
    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int FRAC_W = 8;
    localparam int CNT_W  = 4;

    // Geometry limits.
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4095;

    // Minimum number of significant pixels in the window.
    localparam logic [CNT_W-1:0] MIN_SIGNIFICANT = 4'd3;

    // Saturation limits.
    localparam logic [PIX_W-1:0] SAT_MAX = 8'h7F;
    localparam logic [PIX_W-1:0] SAT_MIN = 8'h80;
    localparam logic [PROD_W-FRAC_W-1:0] SAT_MAX_MAG = 12'd127;
    localparam logic [PROD_W-FRAC_W-1:0] SAT_MIN_MAG = 12'd128;

    // Register reset values.
    localparam logic [CFG_W-1:0]  RST_WIDTH     = 12'd640;
    localparam logic [CFG_W-1:0]  RST_HEIGHT    = 12'd480;
    localparam logic [TH_W-1:0]   RST_THRESHOLD = 8'd8;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 12'd256;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_GAIN         = 2'd3
    } cfg_idx_t;

    // Input item kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Per-item control handed from the counter stage to the datapath.
    typedef struct packed {
        logic [PIX_W-1:0] bot;
        logic             emit;
        logic             border;
        logic             last;
    } dce_item_t;

    // Magnitude of a signed 8-bit sample (128 for the most negative value).
    function automatic logic [MAG_W-1:0] mag8(input logic [PIX_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[PIX_W-1], v};
        return v[PIX_W-1] ? (~ext + MAG_W'(1)) : ext;
    endfunction

endpackage

// File: rtl/core/dce_ram.sv
// ----------------------------------------------------------------------------
// dce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module dce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/dce_ctrl.sv
// ----------------------------------------------------------------------------
// dce_ctrl
// Configuration registers and raster counters. Classifies each accepted
// item, issues the line store read address and tags the item with its
// output position (emit, border, last pixel of frame).
// ----------------------------------------------------------------------------
module dce_ctrl #(
    parameter int MAX_WIDTH = dce_pkg::MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dce_pkg::IDX_W-1:0]     cfg_index,
    input  logic [dce_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_accept,
    input  logic                          kind,
    input  logic [dce_pkg::PIX_W-1:0]     pixel_in,
    output logic                          item_valid,
    output dce_pkg::dce_item_t            item,
    output logic [$clog2(MAX_WIDTH)-1:0]  item_col,
    output logic [dce_pkg::TH_W-1:0]      threshold,
    output logic [dce_pkg::GAIN_W-1:0]    gain
);

    localparam int CBW = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > dce_pkg::CFG_W) ? WW : dce_pkg::CFG_W;
    localparam int RW  = dce_pkg::ROW_W;

    logic [dce_pkg::CFG_W-1:0]  width_reg;
    logic [dce_pkg::CFG_W-1:0]  height_reg;
    logic [dce_pkg::TH_W-1:0]   threshold_reg;
    logic [dce_pkg::GAIN_W-1:0] gain_reg;

    logic [CBW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CBW-1:0] out_x_reg, out_x_next;
    logic [RW-1:0]  out_y_reg, out_y_next;

    logic [CW-1:0] fw_ext;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          done;
    logic          emit;
    logic          col_wrap;
    logic          x_last;
    logic          y_last;
    logic          frame_done;
    logic          restart;

    // Effective geometry, saturated to the supported range.
    always_comb
    begin
        fw_ext = CW'(width_reg);
        if (fw_ext < CW'(dce_pkg::MIN_DIM))
        begin
            w_eff = WW'(dce_pkg::MIN_DIM);
        end
        else if (fw_ext > CW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(fw_ext);
        end

        if (height_reg < RW'(dce_pkg::MIN_DIM))
        begin
            h_eff = RW'(dce_pkg::MIN_DIM);
        end
        else if (height_reg > RW'(dce_pkg::MAX_HEIGHT))
        begin
            h_eff = RW'(dce_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // Item classification and output position.
    always_comb
    begin
        done       = (row_reg >= h_eff);
        item_valid = in_accept && !(!done && (kind == dce_pkg::KIND_FLUSH));
        emit       = done || (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_reg != '0));
        col_wrap   = (WW'(col_reg) == (w_eff - WW'(1)));
        x_last     = (WW'(out_x_reg) == (w_eff - WW'(1)));
        y_last     = (out_y_reg == (h_eff - RW'(1)));
        frame_done = x_last && y_last;

        item.bot    = done ? '0 : pixel_in;
        item.emit   = emit;
        item.border = (out_y_reg == '0) || y_last || (out_x_reg == '0) || x_last;
        item.last   = frame_done;
        item_col    = col_reg;
    end

    // Counter updates.
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        restart    = cfg_we && ((cfg_index == dce_pkg::CFG_FRAME_WIDTH) ||
                                (cfg_index == dce_pkg::CFG_FRAME_HEIGHT));

        if (item_valid)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                if (!done)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CBW'(1);
            end

            if (emit)
            begin
                if (x_last)
                begin
                    out_x_next = '0;
                    out_y_next = out_y_reg + RW'(1);
                end
                else
                begin
                    out_x_next = out_x_reg + CBW'(1);
                end
                if (frame_done)
                begin
                    restart = 1'b1;
                end
            end
        end

        if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            out_x_next = '0;
            out_y_next = '0;
        end
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            out_x_reg <= '0;
            out_y_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= dce_pkg::RST_WIDTH;
            height_reg    <= dce_pkg::RST_HEIGHT;
            threshold_reg <= dce_pkg::RST_THRESHOLD;
            gain_reg      <= dce_pkg::RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dce_pkg::CFG_FRAME_WIDTH:  width_reg     <= cfg_data;
                dce_pkg::CFG_FRAME_HEIGHT: height_reg    <= cfg_data;
                dce_pkg::CFG_THRESHOLD:    threshold_reg <= cfg_data[dce_pkg::TH_W-1:0];
                dce_pkg::CFG_GAIN:         gain_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign threshold = threshold_reg;
    assign gain      = gain_reg;

    // The output column never reaches the line width.
    a_out_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(out_x_reg) < w_eff)
        else $error("output column beyond line width");

    // The input row never passes the frame height.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_eff)
        else $error("input row beyond frame height");

    // The last result of a frame returns all counters to zero.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && emit && frame_done) |=>
            (col_reg == '0) && (row_reg == '0) && (out_x_reg == '0) && (out_y_reg == '0))
        else $error("counters not cleared at frame end");

endmodule

// File: rtl/core/dce_window.sv
// ----------------------------------------------------------------------------
// dce_window
// Window datapath: takes the two previous lines from the line store, keeps
// the two previous window columns, decides coring, scales by the gain,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module dce_window #(
    parameter int MAX_WIDTH = dce_pkg::MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            item_valid,
    input  dce_pkg::dce_item_t              item,
    input  logic [$clog2(MAX_WIDTH)-1:0]    item_col,
    input  logic [dce_pkg::TH_W-1:0]        threshold,
    input  logic [dce_pkg::GAIN_W-1:0]      gain,
    input  logic [2*dce_pkg::PIX_W-1:0]     rd_data,
    output logic                            wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    output logic [2*dce_pkg::PIX_W-1:0]     wr_data,
    output logic                            out_valid,
    output logic [dce_pkg::PIX_W-1:0]       pixel_out,
    output logic                            frame_last
);

    localparam int CBW = $clog2(MAX_WIDTH);
    localparam int PW  = dce_pkg::PIX_W;
    localparam int MW  = dce_pkg::MAG_W;
    localparam int QW  = dce_pkg::PROD_W;
    localparam int NW  = dce_pkg::PROD_W - dce_pkg::FRAC_W;
    localparam int CN  = dce_pkg::CNT_W;

    // Line store read stage.
    logic               s1_valid_reg;
    dce_pkg::dce_item_t s1_item_reg;
    logic [CBW-1:0]     s1_col_reg;
    logic [PW-1:0]      cols_reg [6];

    // Product stage.
    logic               s2_valid_reg;
    logic [QW-1:0]      s2_prod_reg;
    logic               s2_zero_reg;
    logic               s2_border_reg;
    logic [PW-1:0]      s2_centre_reg;
    logic               s2_last_reg;

    // Output register.
    logic               out_valid_reg;
    logic [PW-1:0]      pixel_out_reg;
    logic               frame_last_reg;

    logic [PW-1:0]      top;
    logic [PW-1:0]      mid;
    logic [PW-1:0]      centre;
    logic [PW-1:0]      win [9];
    logic [CN-1:0]      sig_count;
    logic [MW-1:0]      centre_mag;
    logic               core_zero;
    logic [QW-1:0]      prod;
    logic [NW-1:0]      scaled;
    logic [PW-1:0]      result;

    assign top    = rd_data[2*PW-1:PW];
    assign mid    = rd_data[PW-1:0];
    assign centre = cols_reg[4];

    // Write back the shifted line pair at the same column.
    assign wr_en   = adv && s1_valid_reg;
    assign wr_addr = s1_col_reg;
    assign wr_data = {mid, s1_item_reg.bot};

    // Count significant pixels over the window and decide coring.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win[i] = cols_reg[i];
        end
        win[6] = top;
        win[7] = mid;
        win[8] = s1_item_reg.bot;

        sig_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (dce_pkg::mag8(win[i]) > MW'(threshold))
            begin
                sig_count = sig_count + CN'(1);
            end
        end

        centre_mag = dce_pkg::mag8(centre);
        core_zero  = (centre_mag < MW'(threshold)) || (sig_count < dce_pkg::MIN_SIGNIFICANT);
        prod       = QW'(centre_mag) * QW'(gain);
    end

    // Stage registers: valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= item_valid;
            s2_valid_reg  <= s1_valid_reg && s1_item_reg.emit;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Window column shift, one step per item that leaves the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                cols_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cols_reg[0] <= cols_reg[3];
            cols_reg[1] <= cols_reg[4];
            cols_reg[2] <= cols_reg[5];
            cols_reg[3] <= top;
            cols_reg[4] <= mid;
            cols_reg[5] <= s1_item_reg.bot;
        end
    end

    // Stage registers: payload.
    always_ff @(posedge clk)
    begin
        if (adv && item_valid)
        begin
            s1_item_reg <= item;
            s1_col_reg  <= item_col;
        end
        if (adv && s1_valid_reg)
        begin
            s2_prod_reg   <= prod;
            s2_zero_reg   <= core_zero;
            s2_border_reg <= s1_item_reg.border;
            s2_centre_reg <= centre;
            s2_last_reg   <= s1_item_reg.last;
        end
        if (adv && s2_valid_reg)
        begin
            pixel_out_reg  <= result;
            frame_last_reg <= s2_last_reg;
        end
    end

    // Truncate the Q12.8 product and saturate with the sign of the centre.
    always_comb
    begin
        scaled = s2_prod_reg[QW-1:dce_pkg::FRAC_W];
        if (s2_border_reg)
        begin
            result = s2_centre_reg;
        end
        else if (s2_zero_reg)
        begin
            result = '0;
        end
        else if (s2_centre_reg[PW-1])
        begin
            result = (scaled > dce_pkg::SAT_MIN_MAG) ? dce_pkg::SAT_MIN
                                                     : (~scaled[PW-1:0] + PW'(1));
        end
        else
        begin
            result = (scaled > dce_pkg::SAT_MAX_MAG) ? dce_pkg::SAT_MAX : scaled[PW-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

endmodule

// File: rtl/core/detail_coring_enhance_3x3_core.sv
// ----------------------------------------------------------------------------
// detail_coring_enhance_3x3_core
// Detail coring and enhancement over a 3x3 window on a signed high-frequency
// plane in raster order, with two line buffers held in one line store RAM.
// ----------------------------------------------------------------------------
// Throughput: one item per clock cycle unless out_stall holds the pipeline,
// set by one read and one write back per item on the two line store ports.
// Latency: a result passes the read stage, the product stage and the output
// register; in items, results trail the input by one line plus one pixel.
// Reset: rst_n clears counters, valid bits and window columns and loads the
// default configuration; the line store is not cleared.
module detail_coring_enhance_3x3_core #(
    parameter int MAX_WIDTH = dce_pkg::MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dce_pkg::IDX_W-1:0]     cfg_index,
    input  logic [dce_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [dce_pkg::PIX_W-1:0]     pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dce_pkg::PIX_W-1:0]     pixel_out,
    output logic                          frame_last
);

    localparam int CBW = $clog2(MAX_WIDTH);

    logic                          adv;
    logic                          in_accept;
    logic                          item_valid;
    dce_pkg::dce_item_t            item;
    logic [CBW-1:0]                item_col;
    logic [dce_pkg::TH_W-1:0]      threshold;
    logic [dce_pkg::GAIN_W-1:0]    gain;
    logic [2*dce_pkg::PIX_W-1:0]   rd_data;
    logic                          wr_en;
    logic [CBW-1:0]                wr_addr;
    logic [2*dce_pkg::PIX_W-1:0]   wr_data;

    // The pipeline moves whenever the output register is free or drains.
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;
    assign cfg_ready = 1'b1;

    // Configuration and raster counters.
    dce_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .kind       (kind),
        .pixel_in   (pixel_in),
        .item_valid (item_valid),
        .item       (item),
        .item_col   (item_col),
        .threshold  (threshold),
        .gain       (gain)
    );

    // Line store: each word holds the two previous lines at one column.
    dce_ram #(
        .WIDTH (2 * dce_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (item_valid),
        .raddr (item_col),
        .rdata (rd_data)
    );

    // Window, coring, gain and output register.
    dce_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item),
        .item_col   (item_col),
        .threshold  (threshold),
        .gain       (gain),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (out_valid),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule
